>>> rtl/core/kbl_pkg.sv
// ----------------------------------------------------------------------------
// kbl_pkg: shared types for the k-bucket LRU update core
// Contact entry layout, cell control and status groups, result action codes.
// ----------------------------------------------------------------------------
package kbl_pkg;

  localparam int unsigned IdWidth   = 256;
  localparam int unsigned AddrWidth = 48;
  localparam int unsigned OccWidth  = 5;
  localparam int unsigned TdataWidth = 312;

  // One contact: 256-bit id (word 0 in the low bits) and its address
  typedef struct packed {
    logic [AddrWidth-1:0] addr;
    logic [IdWidth-1:0]   id;
  } kbl_entry_t;

  // Control from the sequencer to one cell
  typedef struct packed {
    logic live;   // cell holds a contact (index below fill count)
    logic shift;  // take the neighbor's contact this cycle
  } kbl_cell_ctl_t;

  // Registered compare flags from one cell
  typedef struct packed {
    logic id_hit;    // id matches
    logic full_hit;  // id and address match
  } kbl_cell_sts_t;

  // Result action codes
  typedef enum logic [2:0] {
    ACT_MOVED     = 3'd0,
    ACT_INSERTED  = 3'd1,
    ACT_DISCARDED = 3'd2,
    ACT_EVICTED   = 3'd3,
    ACT_FOUND     = 3'd4,
    ACT_NOT_FOUND = 3'd5
  } kbl_action_e;

endpackage

>>> rtl/core/kbucket_lru_update_core.sv
// ----------------------------------------------------------------------------
// kbucket_lru_update_core: Kademlia k-bucket most-recent-first list
// Refreshes, inserts or evicts contacts and answers exact-match queries.
//
//   channel   dir  tuser           tdata
//   s_axis    in   kind            id words 0..3, address, tail_alive
//   m_axis    out  action          occupancy, evicted id words 0..3, tail addr
//
// A transaction steps through: accept with compare in every cell,
// decide, shift of the cell chain, tail readout into the output register.
// The next input is taken in the cycle after the result is registered.
// A stalled output holds the tail readout stage until the output frees up.
// Reset empties the list; no clearing pass is needed.
// ----------------------------------------------------------------------------
module kbucket_lru_update_core
  import kbl_pkg::*;
#(
  parameter int unsigned BUCKET_DEPTH = 20
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // tdata: id_word0 [63:0], id_word1 [127:64], id_word2 [191:128],
  //        id_word3 [255:192], contact_address [303:256], tail_alive [304]
  input  logic [TdataWidth-1:0] s_axis_tdata,
  // tuser: kind [0]
  input  logic                  s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // tdata: occupancy [4:0], evicted_word0 [68:5], evicted_word1 [132:69],
  //        evicted_word2 [196:133], evicted_word3 [260:197],
  //        tail_address [308:261]
  output logic [TdataWidth-1:0] m_axis_tdata,
  // tuser: action [2:0]
  output logic [2:0]            m_axis_tuser
);

  localparam int unsigned IW = $clog2(BUCKET_DEPTH);
  localparam int unsigned FW = $clog2(BUCKET_DEPTH + 1);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_DEC   = 4'b0010,
    ST_SHIFT = 4'b0100,
    ST_TAIL  = 4'b1000
  } kbl_state_e;

  kbl_state_e    state_q, state_d;
  logic [FW-1:0] fill_q, fill_d;
  logic          kind_q, alive_q;
  kbl_entry_t    key_q, in_key;
  kbl_action_e   act_q, act_d;
  logic [IdWidth-1:0] ev_q, ev_d;
  logic          shift_en_q, shift_en_d;
  logic [IW-1:0] lim_q, lim_d;

  logic               m_valid_q;
  kbl_action_e        out_act_q;
  logic [OccWidth-1:0]  out_occ_q;
  logic [IdWidth-1:0]   out_ev_q;
  logic [AddrWidth-1:0] out_tail_q;

  kbl_entry_t    cell_entry [BUCKET_DEPTH];
  kbl_cell_ctl_t cell_ctl   [BUCKET_DEPTH];
  kbl_cell_sts_t cell_sts   [BUCKET_DEPTH];
  logic [BUCKET_DEPTH-1:0] id_hit, full_hit, tail_sel;

  logic          s_accept, out_load;
  logic          id_any, full_any, bucket_full;
  logic [IW-1:0] hit_idx;
  logic [AddrWidth-1:0] tail_addr;

  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign out_load      = (state_q == ST_TAIL) && (!m_valid_q || m_axis_tready);

  assign in_key.id   = s_axis_tdata[IdWidth-1:0];
  assign in_key.addr = s_axis_tdata[IdWidth +: AddrWidth];

  // Cell chain: slot 0 is the front and takes the key on a shift
  for (genvar i = 0; i < BUCKET_DEPTH; i++) begin : g_cell
    assign cell_ctl[i].live  = (FW'(i) < fill_q);
    assign cell_ctl[i].shift = (state_q == ST_SHIFT) && shift_en_q && (IW'(i) <= lim_q);
    assign id_hit[i]   = cell_sts[i].id_hit;
    assign full_hit[i] = cell_sts[i].full_hit;
    assign tail_sel[i] = (fill_q != '0) && (FW'(i) == (fill_q - FW'(1)));

    kbl_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .cap_i     (s_accept),
      .cmp_key_i (in_key),
      .ctl_i     (cell_ctl[i]),
      .prev_i    ((i == 0) ? key_q : cell_entry[(i == 0) ? 0 : i - 1]),
      .entry_o   (cell_entry[i]),
      .sts_o     (cell_sts[i])
    );
  end

  // Encode the matching slot; ids are unique so at most one cell hits
  always_comb begin
    hit_idx   = '0;
    tail_addr = '0;
    for (int i = 0; i < BUCKET_DEPTH; i++) begin
      hit_idx   = hit_idx | (id_hit[i] ? IW'(i) : '0);
      tail_addr = tail_addr | (tail_sel[i] ? cell_entry[i].addr : '0);
    end
  end

  assign id_any      = |id_hit;
  assign full_any    = |full_hit;
  assign bucket_full = (fill_q == FW'(BUCKET_DEPTH));

  // Decide action, evicted id, shift span and fill count
  always_comb begin
    act_d      = act_q;
    ev_d       = '0;
    shift_en_d = 1'b0;
    lim_d      = '0;
    fill_d     = fill_q;
    if (kind_q) begin
      act_d = full_any ? ACT_FOUND : ACT_NOT_FOUND;
    end else if (id_any) begin
      act_d      = ACT_MOVED;
      shift_en_d = 1'b1;
      lim_d      = hit_idx;
    end else if (!bucket_full) begin
      act_d      = ACT_INSERTED;
      shift_en_d = 1'b1;
      lim_d      = IW'(fill_q);
      fill_d     = fill_q + FW'(1);
    end else if (alive_q) begin
      act_d = ACT_DISCARDED;
    end else begin
      act_d      = ACT_EVICTED;
      shift_en_d = 1'b1;
      lim_d      = IW'(BUCKET_DEPTH - 1);
      ev_d       = cell_entry[BUCKET_DEPTH-1].id;
    end
  end

  // Sequence one transaction through the chain
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (s_accept) state_d = ST_DEC;
      ST_DEC:   state_d = ST_SHIFT;
      ST_SHIFT: state_d = ST_TAIL;
      ST_TAIL:  if (out_load) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      fill_q    <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_DEC) begin
        fill_q <= fill_d;
      end
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // Hold the key and the decision for the later stages
  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      key_q   <= in_key;
      kind_q  <= s_axis_tuser;
      alive_q <= s_axis_tdata[IdWidth + AddrWidth];
    end
    if (state_q == ST_DEC) begin
      act_q      <= act_d;
      ev_q       <= ev_d;
      shift_en_q <= shift_en_d;
      lim_q      <= lim_d;
    end
    if (out_load) begin
      out_act_q  <= act_q;
      out_occ_q  <= OccWidth'(fill_q);
      out_ev_q   <= ev_q;
      out_tail_q <= tail_addr;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = out_act_q;
  assign m_axis_tdata  = {3'b000, out_tail_q, out_ev_q, out_occ_q};

  // Fill count never passes the bucket depth
  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FW'(BUCKET_DEPTH))
    else $error("fill count beyond bucket depth");

  // Held ids are unique, so at most one cell reports an id hit
  a_unique_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DEC) |-> $onehot0(id_hit))
    else $error("more than one cell matched the id");

  // An eviction only happens on a full bucket
  a_evict_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser == ACT_EVICTED)) |->
      (m_axis_tdata[OccWidth-1:0] == OccWidth'(BUCKET_DEPTH)))
    else $error("eviction reported on a bucket that is not full");

  // A result is raised only out of the tail readout stage
  a_tail_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q == ST_TAIL))
    else $error("result raised outside the tail readout stage");

endmodule

>>> rtl/core/kbl_cell.sv
// ----------------------------------------------------------------------------
// kbl_cell: one slot of the contact list
// Holds one contact, compares it against the incoming key and hands its
// contact to the next slot toward the tail when the list shifts.
// ----------------------------------------------------------------------------
module kbl_cell
  import kbl_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cap_i,
  input  kbl_entry_t    cmp_key_i,
  input  kbl_cell_ctl_t ctl_i,
  input  kbl_entry_t    prev_i,
  output kbl_entry_t    entry_o,
  output kbl_cell_sts_t sts_o
);

  kbl_entry_t    entry_q;
  kbl_cell_sts_t sts_q;
  logic          id_eq;

  assign id_eq = ctl_i.live && (entry_q.id == cmp_key_i.id);

  // Capture compare flags when a transaction is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sts_q <= '0;
    end else if (cap_i) begin
      sts_q.id_hit   <= id_eq;
      sts_q.full_hit <= id_eq && (entry_q.addr == cmp_key_i.addr);
    end
  end

  // Advance the neighbor's contact into this slot
  always_ff @(posedge clk_i) begin
    if (ctl_i.shift) begin
      entry_q <= prev_i;
    end
  end

  assign entry_o = entry_q;
  assign sts_o   = sts_q;

endmodule
